### rtl/cmptp_pkg.sv
// Shared types and constants for the cooldown max-pending task picker.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cmptp_pkg;

   localparam int NUM_CLASSES_DEF = 26;
   localparam int COUNT_MAX_DEF   = 255;

   localparam int OP_W    = 2;
   localparam int CLASS_W = 5;
   localparam int COOL_W  = 8;
   localparam int TICK_W  = 16;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

endpackage

`default_nettype wire

### rtl/cooldown_max_pending_task_picker.sv
// Top level of the cooldown max-pending task picker: sequencer, scan compare and result register.
// Depends on cmptp_pkg and on cmptp_ram for the per-class count and cooldown entries.
`timescale 1ns / 1ps
`default_nettype none

// How to use this block:
// A transaction is taken when start is high and busy is low. The op field selects
// an add of one task to req_task_class, a tick, or a clear of all state.
// An add gives no result. A clear sweeps the class RAM to zero and gives no result.
// In a tick the class entries are read one per cycle through the single read port of
// the class RAM; entries in cooldown are counted down, the others are compared against
// the running best, then the winner is written back. The tick result is shown on the
// rsp_ ports for exactly one cycle with rsp_valid high, in the cycle in which busy
// falls. The receiver cannot stall; it must take the result then.
// The user must write the cooldown register through csr_wr_en and csr_wr_data only
// while the block is idle; the block itself does not enforce this. After reset the
// block sweeps the class RAM to zero with busy high; the cooldown register resets to
// zero. A clear keeps the cooldown register. An op value of 3, or an add to a class
// past the last one, is dropped at once.

module cooldown_max_pending_task_picker #(
   parameter int NUM_CLASSES = cmptp_pkg::NUM_CLASSES_DEF,
   parameter int COUNT_MAX   = cmptp_pkg::COUNT_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [cmptp_pkg::OP_W-1:0]        req_op,
   input  wire logic [cmptp_pkg::CLASS_W-1:0]     req_task_class,
   output logic                                   rsp_valid,
   output logic                                   rsp_issued_valid,
   output logic      [cmptp_pkg::CLASS_W-1:0]     rsp_issued_class,
   output logic                                   rsp_work_left,
   output logic      [cmptp_pkg::TICK_W-1:0]      rsp_cycle_number,
   input  wire logic                              csr_wr_en,
   input  wire logic [cmptp_pkg::COOL_W-1:0]      csr_wr_data
);

   localparam int IDX_W = $clog2(NUM_CLASSES);
   localparam int NZ_W  = $clog2(NUM_CLASSES + 1);
   localparam int CNT_W = $clog2(COUNT_MAX + 1);
   localparam int ENT_W = CNT_W + cmptp_pkg::COOL_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CLASSES - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_ISSUE
   } state_type;

   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [IDX_W-1:0]                best_ff, best_in;
   logic [CNT_W-1:0]                best_cnt_ff, best_cnt_in;
   logic                            found_ff, found_in;
   logic [NZ_W-1:0]                 nz_ff, nz_in;
   logic [cmptp_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [cmptp_pkg::COOL_W-1:0]    cooldown_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_issued_valid_ff, rsp_issued_valid_in;
   logic [cmptp_pkg::CLASS_W-1:0]   rsp_issued_class_ff, rsp_issued_class_in;
   logic                            rsp_work_left_ff, rsp_work_left_in;
   logic [cmptp_pkg::TICK_W-1:0]    rsp_cycle_number_ff, rsp_cycle_number_in;

   logic                            ram_we;
   logic [IDX_W-1:0]                ram_waddr;
   logic [ENT_W-1:0]                ram_wdata;
   logic [IDX_W-1:0]                ram_raddr;
   logic [ENT_W-1:0]                ram_rdata;

   logic [cmptp_pkg::COOL_W-1:0]    rd_cool;
   logic [CNT_W-1:0]                rd_cnt;
   logic [6:0]                      cls_ext;
   logic                            cls_ok;
   logic [6:0]                      best_ext;
   cmptp_pkg::op_type               op;

   cmptp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_CLASSES)
   ) u_class_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_cool  = ram_rdata[CNT_W +: cmptp_pkg::COOL_W];
   assign rd_cnt   = ram_rdata[CNT_W-1:0];
   assign cls_ext  = {2'b00, req_task_class};
   assign cls_ok   = cls_ext < 7'(NUM_CLASSES);
   assign best_ext = 7'(best_ff);
   assign op       = cmptp_pkg::op_type'(req_op);

   always_comb begin
      state_in            = state_ff;
      idx_in              = idx_ff;
      best_in             = best_ff;
      best_cnt_in         = best_cnt_ff;
      found_in            = found_ff;
      nz_in               = nz_ff;
      tick_in             = tick_ff;
      rsp_valid_in        = 1'b0;
      rsp_issued_valid_in = rsp_issued_valid_ff;
      rsp_issued_class_in = rsp_issued_class_ff;
      rsp_work_left_in    = rsp_work_left_ff;
      rsp_cycle_number_in = rsp_cycle_number_ff;
      ram_we              = 1'b0;
      ram_waddr           = idx_ff;
      ram_wdata           = '0;
      ram_raddr           = idx_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (op)
                  cmptp_pkg::OP_ADD: begin
                     if (cls_ok) begin
                        ram_raddr = cls_ext[IDX_W-1:0];
                        idx_in    = cls_ext[IDX_W-1:0];
                        state_in  = ST_ADD;
                     end
                  end
                  cmptp_pkg::OP_TICK: begin
                     ram_raddr   = '0;
                     idx_in      = '0;
                     best_in     = '0;
                     best_cnt_in = '0;
                     found_in    = 1'b0;
                     if (tick_ff != cmptp_pkg::TICK_MAX) begin
                        tick_in = tick_ff + cmptp_pkg::TICK_W'(1);
                     end
                     state_in = ST_SCAN;
                  end
                  cmptp_pkg::OP_CLEAR: begin
                     idx_in   = '0;
                     tick_in  = '0;
                     nz_in    = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (rd_cnt < CNT_LIMIT) begin
               ram_we    = 1'b1;
               ram_wdata = {rd_cool, rd_cnt + CNT_W'(1)};
            end
            if (rd_cnt == '0) begin
               nz_in = nz_ff + NZ_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            ram_raddr = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
            if (rd_cool != '0) begin
               ram_we    = 1'b1;
               ram_wdata = {rd_cool - cmptp_pkg::COOL_W'(1), rd_cnt};
            end else if (rd_cnt > best_cnt_ff) begin
               best_in     = idx_ff;
               best_cnt_in = rd_cnt;
               found_in    = 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_ISSUE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_ISSUE: begin
            if (found_ff) begin
               ram_we    = 1'b1;
               ram_waddr = best_ff;
               ram_wdata = {cooldown_ff, best_cnt_ff - CNT_W'(1)};
               if (best_cnt_ff == CNT_W'(1)) begin
                  nz_in = nz_ff - NZ_W'(1);
               end
            end
            rsp_valid_in        = 1'b1;
            rsp_issued_valid_in = found_ff;
            rsp_issued_class_in = found_ff ? best_ext[cmptp_pkg::CLASS_W-1:0] : '0;
            rsp_work_left_in    = (nz_in != '0);
            rsp_cycle_number_in = tick_ff;
            idx_in              = '0;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         best_ff      <= '0;
         best_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         nz_ff        <= '0;
         tick_ff      <= '0;
         cooldown_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         best_ff      <= best_in;
         best_cnt_ff  <= best_cnt_in;
         found_ff     <= found_in;
         nz_ff        <= nz_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cooldown_ff <= csr_wr_data;
         end
      end
      rsp_issued_valid_ff <= rsp_issued_valid_in;
      rsp_issued_class_ff <= rsp_issued_class_in;
      rsp_work_left_ff    <= rsp_work_left_in;
      rsp_cycle_number_ff <= rsp_cycle_number_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_issued_valid = rsp_issued_valid_ff;
   assign rsp_issued_class = rsp_issued_class_ff;
   assign rsp_work_left    = rsp_work_left_ff;
   assign rsp_cycle_number = rsp_cycle_number_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("Block is not sweeping the class RAM after reset.");

   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(state_ff == ST_ISSUE))
      else $error("Result strobe does not follow the issue step.");

   a_idle_class_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_issued_valid) |-> (rsp_issued_class == '0))
      else $error("Idle tick reports a nonzero class.");

   a_nz_bounded: assert property (@(posedge clock) disable iff (reset)
      nz_ff <= NZ_W'(NUM_CLASSES))
      else $error("Count of nonempty classes exceeds the number of classes.");

   a_issue_means_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && found_ff && best_cnt_ff > CNT_W'(1)) |=> rsp_work_left)
      else $error("Work left is low although the issued class still has tasks.");
`endif

endmodule

`default_nettype wire

### rtl/cmptp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the per-class entries of the task picker.
`timescale 1ns / 1ps
`default_nettype none

module cmptp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for cooldown_max_pending_task_picker: it drives adds, ticks,
// clears and cooldown writes, and checks every tick result against a predictor.
// Depends on cmptp_pkg and the top level of the block.
`timescale 1ns / 1ps

module testbench;

   localparam int NCLS = cmptp_pkg::NUM_CLASSES_DEF;
   localparam int CMAX = cmptp_pkg::COUNT_MAX_DEF;
   localparam int OP_W = cmptp_pkg::OP_W;
   localparam int CLASS_W = cmptp_pkg::CLASS_W;
   localparam int COOL_W = cmptp_pkg::COOL_W;
   localparam int TICK_W = cmptp_pkg::TICK_W;
   localparam logic [TICK_W-1:0] TICK_MAX = cmptp_pkg::TICK_MAX;
   localparam logic [OP_W-1:0] OP_ADD = cmptp_pkg::OP_ADD;
   localparam logic [OP_W-1:0] OP_TICK = cmptp_pkg::OP_TICK;
   localparam logic [OP_W-1:0] OP_CLEAR = cmptp_pkg::OP_CLEAR;
   localparam int CLASS_TOP = (1 << CLASS_W) - 1;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = NCLS + 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 55;
   localparam int FLOOD_TICKS = 40;

   typedef struct packed {
      logic               issued_valid;
      logic [CLASS_W-1:0] issued_class;
      logic               work_left;
      logic [TICK_W-1:0]  cycle_number;
   } tick_result_type;

   class pick_scoreboard;
      int                pend_cnt [NCLS];
      int                wait_left [NCLS];
      logic [TICK_W-1:0] tick_cnt;
      logic [COOL_W-1:0] cool_reg;
      tick_result_type   expected_ticks [$];
      int                error_count;

      function new();
         cool_reg = '0;
         error_count = 0;
         clear_state();
      endfunction

      function void clear_state();
         for (int i = 0; i < NCLS; i++) begin
            pend_cnt[i] = 0;
            wait_left[i] = 0;
         end
         tick_cnt = '0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [CLASS_W-1:0] cls);
         tick_result_type res;
         int              best;
         int              best_cnt;
         bit              found;
         bit              left;
         best = 0;
         best_cnt = 0;
         found = 1'b0;
         left = 1'b0;
         if (op == OP_ADD) begin
            if (int'(cls) < NCLS && pend_cnt[cls] < CMAX)
               pend_cnt[cls]++;
         end else if (op == OP_CLEAR) begin
            clear_state();
         end else if (op == OP_TICK) begin
            if (tick_cnt != TICK_MAX)
               tick_cnt++;
            for (int i = 0; i < NCLS; i++) begin
               if (wait_left[i] != 0) begin
                  wait_left[i]--;
               end else if (pend_cnt[i] > best_cnt) begin
                  best_cnt = pend_cnt[i];
                  best = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               pend_cnt[best]--;
               wait_left[best] = int'(cool_reg);
            end
            for (int i = 0; i < NCLS; i++)
               if (pend_cnt[i] != 0)
                  left = 1'b1;
            res.issued_valid = found;
            res.issued_class = found ? CLASS_W'(best) : '0;
            res.work_left = left;
            res.cycle_number = tick_cnt;
            expected_ticks.push_back(res);
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         error_count++;
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      endtask

      task check_tick(tick_result_type got);
         tick_result_type want;
         if (expected_ticks.size() == 0) begin
            report_mismatch("result with no tick outstanding", 1, 0);
         end else begin
            want = expected_ticks.pop_front();
            if (got.issued_valid !== want.issued_valid)
               report_mismatch("issued_valid", got.issued_valid, want.issued_valid);
            if (got.issued_class !== want.issued_class)
               report_mismatch("issued_class", got.issued_class, want.issued_class);
            if (got.work_left !== want.work_left)
               report_mismatch("work_left", got.work_left, want.work_left);
            if (got.cycle_number !== want.cycle_number)
               report_mismatch("cycle_number", got.cycle_number, want.cycle_number);
         end
      endtask

      task check_drained();
         if (expected_ticks.size() != 0)
            report_mismatch("tick results never seen", expected_ticks.size(), 0);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [OP_W-1:0]    req_op;
   logic [CLASS_W-1:0] req_task_class;
   logic               rsp_valid;
   logic               rsp_issued_valid;
   logic [CLASS_W-1:0] rsp_issued_class;
   logic               rsp_work_left;
   logic [TICK_W-1:0]  rsp_cycle_number;
   logic               csr_wr_en;
   logic [COOL_W-1:0]  csr_wr_data;

   pick_scoreboard sb;
   bit             no_idle;
   int             cycle_count;

   cooldown_max_pending_task_picker #(
      .NUM_CLASSES(NCLS),
      .COUNT_MAX  (CMAX)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_task_class  (req_task_class),
      .rsp_valid       (rsp_valid),
      .rsp_issued_valid(rsp_issued_valid),
      .rsp_issued_class(rsp_issued_class),
      .rsp_work_left   (rsp_work_left),
      .rsp_cycle_number(rsp_cycle_number),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** cooldown_max_pending_task_picker: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_tick({rsp_issued_valid, rsp_issued_class, rsp_work_left, rsp_cycle_number});
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [CLASS_W-1:0] cls);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_task_class <= cls;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(op, cls);
   endtask

   task automatic settle_idle();
      start <= 1'b0;
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_cooldown(logic [COOL_W-1:0] value);
      settle_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.cool_reg = value;
   endtask

   task automatic run_directed();
      send_item(OP_TICK, 5'd0);
      send_item(OP_UNUSED, CLASS_W'(CLASS_TOP));
      send_item(OP_ADD, 5'd0);
      send_item(OP_ADD, CLASS_W'(NCLS - 1));
      send_item(OP_ADD, CLASS_W'(NCLS));
      send_item(OP_ADD, CLASS_W'(CLASS_TOP));
      send_item(OP_TICK, 5'd0);
      send_item(OP_TICK, CLASS_W'(CLASS_TOP));
      send_item(OP_TICK, 5'd0);
      send_item(OP_ADD, 5'd4);
      send_item(OP_ADD, 5'd4);
      send_item(OP_ADD, 5'd9);
      send_item(OP_ADD, 5'd9);
      send_item(OP_ADD, 5'd9);
      send_item(OP_TICK, 5'd0);
      send_item(OP_TICK, 5'd0);
      send_item(OP_ADD, 5'd12);
      send_item(OP_CLEAR, CLASS_W'(CLASS_TOP));
      send_item(OP_TICK, 5'd0);
      send_item(OP_ADD, 5'd3);
      send_item(OP_TICK, 5'd0);
   endtask

   task automatic run_random(int n_items);
      int                 counted;
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [CLASS_W-1:0] cls;
      counted = 0;
      while (counted < n_items) begin
         if (counted % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 50)
            op = OP_ADD;
         else if (pick < 95)
            op = OP_TICK;
         else if (pick < 97)
            op = OP_CLEAR;
         else
            op = OP_UNUSED;
         pick = $urandom_range(0, 99);
         if (pick < 8)
            cls = CLASS_W'($urandom_range(NCLS, CLASS_TOP));
         else if (pick < 40)
            cls = CLASS_W'($urandom_range(0, 3));
         else
            cls = CLASS_W'($urandom_range(0, NCLS - 1));
         send_item(op, cls);
         if (op != OP_UNUSED && !(op == OP_ADD && int'(cls) >= NCLS))
            counted++;
      end
   endtask

   // Pushes one class past its count limit, then ticks a number of times.
   task automatic run_flood(int n_ticks);
      logic [CLASS_W-1:0] cls;
      cls = CLASS_W'($urandom_range(0, NCLS - 1));
      repeat ($urandom_range(CMAX + 1, CMAX + 15)) send_item(OP_ADD, cls);
      repeat (n_ticks) send_item(OP_TICK, cls);
   endtask

   initial begin
      sb = new();
      no_idle = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_ADD;
      req_task_class <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      run_directed();

      write_cooldown(8'd255);
      run_random(PHASE_ITEMS);
      write_cooldown(8'd1);
      run_flood(FLOOD_TICKS);
      run_random(PHASE_ITEMS);
      write_cooldown(8'd2);
      run_random(PHASE_ITEMS);
      write_cooldown(COOL_W'(NCLS - 1));
      run_random(PHASE_ITEMS);
      write_cooldown(COOL_W'(NCLS));
      run_random(PHASE_ITEMS);
      write_cooldown(COOL_W'($urandom_range(3, 24)));
      run_random(PHASE_ITEMS);
      write_cooldown(COOL_W'($urandom_range(0, 255)));
      run_random(PHASE_ITEMS);
      write_cooldown(8'd0);
      run_flood(FLOOD_TICKS);
      run_random(PHASE_ITEMS);

      settle_idle();
      sb.check_drained();
      if (sb.error_count == 0)
         $display("** cooldown_max_pending_task_picker: PASSED **");
      else
         $display("** cooldown_max_pending_task_picker: FAILED **");
      $finish;
   end

endmodule

### files.f
rtl/cmptp_pkg.sv
rtl/cmptp_ram.sv
rtl/cooldown_max_pending_task_picker.sv
tb/testbench.sv
